// File: sv/stfr_pkg.sv
`default_nettype none

package stfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 16;

    // SLIP symbols
    localparam logic [7:0] SYM_END     = 8'hC0;
    localparam logic [7:0] SYM_ESC     = 8'hDB;
    localparam logic [7:0] SYM_ESC_END = 8'hDC;
    localparam logic [7:0] SYM_ESC_ESC = 8'hDD;

    localparam logic [7:0] SOURCE_ADDR    = 8'h11;
    localparam logic [7:0] CTRL_READ_FILE = 8'hA7;
    localparam logic [7:0] CTRL_DIAG      = 8'hA4;

    // File addresses of the read-address reply
    localparam logic [7:0] FA_TEMPERATURE = 8'h03;
    localparam logic [7:0] FA_SPEED       = 8'h15;
    localparam logic [7:0] FA_SUPPLY      = 8'h02;
    localparam logic [7:0] FA_UPSETS      = 8'h18;
    localparam logic [7:0] FA_FAULT       = 8'h19;
    localparam logic [7:0] FA_DIAG        = 8'h00;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNKNOWN_FA  = 3'd1,
        ST_BAD_ESCAPE  = 3'd2,
        ST_NO_END      = 3'd3,
        ST_OVERFLOW    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        QTY_NONE        = 3'd0,
        QTY_TEMPERATURE = 3'd1,
        QTY_SPEED       = 3'd2,
        QTY_SUPPLY      = 3'd3,
        QTY_UPSETS      = 3'd4,
        QTY_FAULT       = 3'd5,
        QTY_RESET_CAUSE = 3'd6
    } quantity_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_ENDED   = 2'd2,
        PH_HALTED  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_of_read;
        logic       last_of_read;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic       crc_ok;
        quantity_t  quantity;
        logic [31:0] value;
    } result_t;

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_SRC_SEED = crc16_byte(CRC_INIT, SOURCE_ADDR);

endpackage

`default_nettype wire

// File: sv/stfr_in_stage.sv
`default_nettype none

module stfr_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire stfr_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output stfr_pkg::item_t    item
);
    import stfr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Refill in the same cycle the held item moves on
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/stfr_deframer.sv
`default_nettype none

module stfr_deframer #(
    parameter int MAX_FRAME_BYTES = stfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [7:0]      cfg_wr_data,
    input  wire logic            take,
    input  wire stfr_pkg::item_t item,
    output stfr_pkg::result_t    result
);
    import stfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);

    phase_t            phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        ctrl_reg, ctrl_next;
    logic [7:0]        fa_reg, fa_next;
    logic [31:0]       pay_reg, pay_next;
    logic              ovf_reg, ovf_next;
    logic [15:0]       seed_reg;

    phase_t            ph;
    logic              esc;
    logic [CNT_W-1:0]  cnt;
    logic [15:0]       crc;
    logic [7:0]        ctrl;
    logic [7:0]        fa;
    logic [31:0]       pay;
    logic              ovf;
    logic              store;
    logic [7:0]        dbyte;

    // CRC over source and device address is fixed per read; fold it at write time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= crc16_byte(CRC_SRC_SEED, 8'h00);
        end else if (cfg_wr_en) begin
            seed_reg <= crc16_byte(CRC_SRC_SEED, cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            esc_reg   <= 1'b0;
            cnt_reg   <= '0;
            crc_reg   <= CRC_INIT;
            ctrl_reg  <= '0;
            fa_reg    <= '0;
            pay_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            ctrl_reg  <= ctrl_next;
            fa_reg    <= fa_next;
            pay_reg   <= pay_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb begin
        ph    = phase_reg;
        esc   = esc_reg;
        cnt   = cnt_reg;
        crc   = crc_reg;
        ctrl  = ctrl_reg;
        fa    = fa_reg;
        pay   = pay_reg;
        ovf   = ovf_reg;
        store = 1'b0;
        dbyte = item.rx_byte;

        // Drop any read in progress
        if (item.first_of_read) begin
            ph   = PH_IDLE;
            esc  = 1'b0;
            cnt  = '0;
            crc  = CRC_INIT;
            ctrl = '0;
            fa   = '0;
            pay  = '0;
            ovf  = 1'b0;
        end

        if (ph == PH_IDLE) begin
            crc = seed_reg;
            ph  = PH_COLLECT;
        end

        if (ph == PH_COLLECT) begin
            if (esc) begin
                esc = 1'b0;
                if (item.rx_byte == SYM_ESC_END) begin
                    store = 1'b1;
                    dbyte = SYM_END;
                end else if (item.rx_byte == SYM_ESC_ESC) begin
                    store = 1'b1;
                    dbyte = SYM_ESC;
                end else begin
                    ph  = PH_HALTED;
                    ovf = 1'b0;
                end
            end else if (item.rx_byte == SYM_END) begin
                ph = PH_ENDED;
            end else if (item.rx_byte == SYM_ESC) begin
                esc = 1'b1;
            end else begin
                store = 1'b1;
            end
        end

        if (store) begin
            // Leave room for the end marker
            if ({1'b0, cnt} + (CNT_W+1)'(1) >= (CNT_W+1)'(MAX_FRAME_BYTES)) begin
                ph  = PH_HALTED;
                ovf = 1'b1;
            end else begin
                case (cnt)
                    CNT_W'(0): ctrl = dbyte;
                    CNT_W'(1): fa = dbyte;
                    CNT_W'(2): pay[7:0] = dbyte;
                    CNT_W'(3): pay[15:8] = dbyte;
                    CNT_W'(4): pay[23:16] = dbyte;
                    CNT_W'(5): pay[31:24] = dbyte;
                    default: ;
                endcase
                crc = crc16_byte(crc, dbyte);
                cnt = cnt + CNT_W'(1);
            end
        end

        result.status   = ST_OK;
        result.crc_ok   = 1'b0;
        result.quantity = QTY_NONE;
        result.value    = '0;
        case (ph)
            PH_ENDED: begin
                result.crc_ok = (crc == 16'h0000);
                if (ctrl == CTRL_READ_FILE) begin
                    case (fa)
                        FA_TEMPERATURE: result.quantity = QTY_TEMPERATURE;
                        FA_SPEED:       result.quantity = QTY_SPEED;
                        FA_SUPPLY:      result.quantity = QTY_SUPPLY;
                        FA_UPSETS:      result.quantity = QTY_UPSETS;
                        FA_FAULT:       result.quantity = QTY_FAULT;
                        default:        result.status = ST_UNKNOWN_FA;
                    endcase
                end else if (ctrl == CTRL_DIAG && fa == FA_DIAG) begin
                    result.quantity = QTY_RESET_CAUSE;
                end
                if (result.quantity != QTY_NONE) begin
                    result.value = pay;
                end
            end
            PH_HALTED: result.status = ovf ? ST_OVERFLOW : ST_BAD_ESCAPE;
            default:   result.status = ST_NO_END;
        endcase

        phase_next = phase_reg;
        esc_next   = esc_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        ctrl_next  = ctrl_reg;
        fa_next    = fa_reg;
        pay_next   = pay_reg;
        ovf_next   = ovf_reg;
        if (take) begin
            if (item.last_of_read) begin
                phase_next = PH_IDLE;
                esc_next   = 1'b0;
                cnt_next   = '0;
                crc_next   = CRC_INIT;
                ctrl_next  = '0;
                fa_next    = '0;
                pay_next   = '0;
                ovf_next   = 1'b0;
            end else begin
                phase_next = ph;
                esc_next   = esc;
                cnt_next   = cnt;
                crc_next   = crc;
                ctrl_next  = ctrl;
                fa_next    = fa;
                pay_next   = pay;
                ovf_next   = ovf;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/stfr_out_stage.sv
`default_nettype none

module stfr_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire stfr_pkg::result_t result,
    output logic                   busy,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output stfr_pkg::result_t      m_result
);
    import stfr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign m_valid  = valid_reg;
    assign m_result = result_reg;
    // Hold off new work only while a result waits and the sink stalls
    assign busy     = valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: sv/slip_telemetry_frame_receiver.sv
// SLIP telemetry frame receiver.
// Input channel (s_valid/s_ready): one raw received byte per item, with
// s_first_of_read starting a new read and s_last_of_read closing it.
// Result channel (m_valid/m_ready): one item per read, issued for the byte
// that carries s_last_of_read: status, CRC flag, quantity and 32-bit value.
// cfg_wr_en/cfg_wr_data set the device address used in the CRC; write it
// only while no read is in flight.
// A byte is decoded out of the input register once the result register can
// take its outcome, which for the last byte of a read is loaded there and
// raises m_valid. Throughput is one byte per cycle unless a result waits on
// low m_ready; the decode and a byte-wide CRC update sit in a single stage.
// When m_ready is low and a result is waiting, the input register holds the
// next byte and s_ready falls once it is full; nothing is dropped.
// Reset (aresetn low, synchronous) clears both registers, the decoder state
// and the device address (zero).
`default_nettype none

module slip_telemetry_frame_receiver #(
    parameter int MAX_FRAME_BYTES = stfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_first_of_read,
    input  wire logic        s_last_of_read,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_crc_ok,
    output logic [2:0]       m_quantity,
    output logic [31:0]      m_value
);
    import stfr_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    busy;
    result_t result;
    result_t m_result;

    assign s_item.rx_byte       = s_rx_byte;
    assign s_item.first_of_read = s_first_of_read;
    assign s_item.last_of_read  = s_last_of_read;

    // Advance a held byte whenever the result register can take its outcome
    assign take = item_valid && !busy;

    stfr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    stfr_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .item        (item),
        .result      (result)
    );

    stfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && item.last_of_read),
        .result   (result),
        .busy     (busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_status   = m_result.status;
    assign m_crc_ok   = m_result.crc_ok;
    assign m_quantity = m_result.quantity;
    assign m_value    = m_result.value;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
import stfr_pkg::*;

class telemetry_scoreboard;
    logic [7:0]  dev_addr;
    phase_t      rd_phase;
    bit          esc_pending;
    int          decoded_count;
    logic [15:0] crc;
    logic [7:0]  ctrl_byte;
    logic [7:0]  fa_byte;
    logic [31:0] payload;
    bit          halt_overflow;
    result_t     expected_replies[$];
    int          errors;

    function new();
        dev_addr = 8'h00;
        errors = 0;
        clear_read();
    endfunction

    // Reflected CCITT update, one bit at a time, LSB first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        bit fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function void clear_read();
        rd_phase = PH_IDLE;
        esc_pending = 1'b0;
        decoded_count = 0;
        crc = CRC_INIT;
        ctrl_byte = 8'h00;
        fa_byte = 8'h00;
        payload = 32'h0;
        halt_overflow = 1'b0;
    endfunction

    function void store_decoded(logic [7:0] d);
        // Reserve one slot for the end marker
        if (decoded_count + 1 >= MAX_FRAME_BYTES_DEF) begin
            rd_phase = PH_HALTED;
            halt_overflow = 1'b1;
            return;
        end
        if (decoded_count == 0) begin
            ctrl_byte = d;
        end else if (decoded_count == 1) begin
            fa_byte = d;
        end else if (decoded_count <= 5) begin
            payload[8*(decoded_count-2) +: 8] = d;
        end
        crc = crc_step(crc, d);
        decoded_count++;
    endfunction

    function void note_rx_byte(logic [7:0] b, logic first, logic last);
        result_t r;
        if (first) begin
            clear_read();
        end
        if (rd_phase == PH_IDLE) begin
            crc = crc_step(crc_step(CRC_INIT, SOURCE_ADDR), dev_addr);
            rd_phase = PH_COLLECT;
        end
        if (rd_phase == PH_COLLECT) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (b == SYM_ESC_END) begin
                    store_decoded(SYM_END);
                end else if (b == SYM_ESC_ESC) begin
                    store_decoded(SYM_ESC);
                end else begin
                    rd_phase = PH_HALTED;
                    halt_overflow = 1'b0;
                end
            end else if (b == SYM_END) begin
                rd_phase = PH_ENDED;
            end else if (b == SYM_ESC) begin
                esc_pending = 1'b1;
            end else begin
                store_decoded(b);
            end
        end
        if (!last) begin
            return;
        end

        r = '0;
        r.status = ST_OK;
        r.quantity = QTY_NONE;
        case (rd_phase)
            PH_ENDED: begin
                r.crc_ok = (crc == 16'h0000);
                if (ctrl_byte == CTRL_READ_FILE) begin
                    case (fa_byte)
                        FA_TEMPERATURE: r.quantity = QTY_TEMPERATURE;
                        FA_SPEED:       r.quantity = QTY_SPEED;
                        FA_SUPPLY:      r.quantity = QTY_SUPPLY;
                        FA_UPSETS:      r.quantity = QTY_UPSETS;
                        FA_FAULT:       r.quantity = QTY_FAULT;
                        default:        r.status = ST_UNKNOWN_FA;
                    endcase
                end else if (ctrl_byte == CTRL_DIAG && fa_byte == FA_DIAG) begin
                    r.quantity = QTY_RESET_CAUSE;
                end
                if (r.quantity != QTY_NONE) begin
                    r.value = payload;
                end
            end
            PH_HALTED: r.status = halt_overflow ? ST_OVERFLOW : ST_BAD_ESCAPE;
            default:   r.status = ST_NO_END;
        endcase
        expected_replies.push_back(r);
        clear_read();
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
        errors++;
    endfunction

    function void check_reply(logic [2:0] st, logic ok, logic [2:0] qty, logic [31:0] val);
        result_t e;
        if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply: status %0d crc_ok %0d quantity %0d value 0x%0h",
                     $time, st, ok, qty, val);
            errors++;
            return;
        end
        e = expected_replies.pop_front();
        if (st !== e.status)    report("status", 32'(e.status), 32'(st));
        if (ok !== e.crc_ok)    report("crc_ok", 32'(e.crc_ok), 32'(ok));
        if (qty !== e.quantity) report("quantity", 32'(e.quantity), 32'(qty));
        if (val !== e.value)    report("value", e.value, val);
    endfunction
endclass

module tb_top;
    localparam int RANDOM_ITEMS_PER_PHASE = 350;
    localparam int NUM_PHASES = 5;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_first_of_read = 1'b0;
    logic        s_last_of_read = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_crc_ok;
    logic [2:0]  m_quantity;
    logic [31:0] m_value;

    telemetry_scoreboard sb = new();
    logic [7:0] frame_bytes[$];
    int  items_sent = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  stall_left = 0;

    slip_telemetry_frame_receiver i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_first_of_read (s_first_of_read),
        .s_last_of_read  (s_last_of_read),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_crc_ok        (m_crc_ok),
        .m_quantity      (m_quantity),
        .m_value         (m_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Lean toward the SLIP symbols so escapes show up often
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 5))
                0: b = SYM_END;
                1: b = SYM_ESC;
                2: b = SYM_ESC_END;
                3: b = SYM_ESC_ESC;
                4: b = 8'h00;
                default: b = 8'hFF;
            endcase
        end
        return b;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_reply(m_status, m_crc_ok, m_quantity, m_value);
        end
        if ($urandom_range(0, 299) == 0) begin
            rx_burst = !rx_burst;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!rx_burst) begin
                stall_left = idle_len();
            end
        end
    end

    task automatic send_item(logic [7:0] b, logic first, logic last);
        int gap;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        s_first_of_read <= first;
        s_last_of_read <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_rx_byte(b, first, last);
        items_sent++;
    endtask

    task automatic send_read(bit mark_first);
        tx_burst = ($urandom_range(0, 7) == 0);
        foreach (frame_bytes[i]) begin
            send_item(frame_bytes[i], mark_first && (i == 0), i == frame_bytes.size() - 1);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_device_address(logic [7:0] a);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.dev_addr = a;
    endtask

    task automatic build_random_read();
        logic [7:0]  dec[$];
        logic [7:0]  ctrl;
        logic [7:0]  fa;
        logic [7:0]  bad;
        logic [15:0] crc;
        int          pick;
        int          keep;
        int          target;
        int          pos;
        dec = {};
        frame_bytes = {};

        pick = $urandom_range(0, 99);
        if (pick < 55) ctrl = CTRL_READ_FILE;
        else if (pick < 75) ctrl = CTRL_DIAG;
        else ctrl = 8'($urandom);
        pick = $urandom_range(0, 9);
        fa = 8'($urandom);
        if (ctrl == CTRL_DIAG) begin
            if (pick < 7) fa = FA_DIAG;
        end else if (pick < 8) begin
            case ($urandom_range(0, 5))
                0: fa = FA_TEMPERATURE;
                1: fa = FA_SPEED;
                2: fa = FA_SUPPLY;
                3: fa = FA_UPSETS;
                4: fa = FA_FAULT;
                default: fa = FA_DIAG;
            endcase
        end
        dec.push_back(ctrl);
        dec.push_back(fa);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 3)) dec.push_back(data_byte());
            // occasionally cut the header too
            if ($urandom_range(0, 3) == 0) begin
                keep = $urandom_range(0, 1);
                while (dec.size() > keep) void'(dec.pop_back());
            end
        end else begin
            repeat (4) dec.push_back(data_byte());
        end
        // pad around the frame size limit
        if ($urandom_range(0, 9) == 0) begin
            target = $urandom_range(13, 17);
            while (dec.size() + 2 < target) dec.push_back(data_byte());
        end

        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            crc = sb.crc_step(sb.crc_step(CRC_INIT, SOURCE_ADDR), sb.dev_addr);
            foreach (dec[i]) crc = sb.crc_step(crc, dec[i]);
            if (pick >= 72) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            dec.push_back(crc[7:0]);
            dec.push_back(crc[15:8]);
        end

        foreach (dec[i]) begin
            if (dec[i] == SYM_END) begin
                frame_bytes.push_back(SYM_ESC);
                frame_bytes.push_back(SYM_ESC_END);
            end else if (dec[i] == SYM_ESC) begin
                frame_bytes.push_back(SYM_ESC);
                frame_bytes.push_back(SYM_ESC_ESC);
            end else begin
                frame_bytes.push_back(dec[i]);
            end
        end

        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            // broken escape somewhere in the frame
            if ($urandom_range(0, 2) == 0) begin
                bad = SYM_END;
            end else begin
                do bad = 8'($urandom); while (bad == SYM_ESC_END || bad == SYM_ESC_ESC);
            end
            pos = $urandom_range(0, frame_bytes.size());
            frame_bytes.insert(pos, bad);
            frame_bytes.insert(pos, SYM_ESC);
            frame_bytes.push_back(SYM_END);
        end else if (pick < 12) begin
            // no end marker, sometimes with a dangling escape
            if ($urandom_range(0, 1) == 0) frame_bytes.push_back(SYM_ESC);
        end else begin
            frame_bytes.push_back(SYM_END);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
            end
        end
        if (frame_bytes.size() == 0) frame_bytes.push_back(SYM_ESC);
    endtask

    task automatic run_directed();
        frame_bytes = {SYM_END};
        send_read(1'b1);
        frame_bytes = {8'h00};
        send_read(1'b1);
        frame_bytes = {SYM_ESC, SYM_END};
        send_read(1'b1);
        frame_bytes = {SYM_ESC, 8'h41, SYM_END};
        send_read(1'b1);
        // no start flag while idle still opens a read
        frame_bytes = {SYM_ESC};
        send_read(1'b0);
        frame_bytes = {CTRL_READ_FILE, FA_TEMPERATURE, SYM_END};
        send_read(1'b1);
        frame_bytes = {CTRL_READ_FILE, 8'h99, SYM_END};
        send_read(1'b1);
        frame_bytes = {CTRL_DIAG, FA_DIAG, SYM_ESC, SYM_ESC_END, SYM_ESC, SYM_ESC_ESC,
                       8'hFF, SYM_END, 8'h5A};
        send_read(1'b1);
        frame_bytes = {CTRL_DIAG, 8'h05, SYM_END};
        send_read(1'b1);
        // abandon a read mid-way with a new start
        send_item(8'h12, 1'b1, 1'b0);
        frame_bytes = {CTRL_READ_FILE, FA_SPEED, 8'h01, SYM_END};
        send_read(1'b1);
    endtask

    initial begin
        int goal;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: set_device_address(8'hFF);
                1: set_device_address(8'h00);
                default: set_device_address(8'($urandom));
            endcase
            goal = items_sent + RANDOM_ITEMS_PER_PHASE;
            while (items_sent < goal) begin
                if ($urandom_range(0, 24) == 0) begin
                    // partial read that the next start flag drops
                    tx_burst = 1'b0;
                    send_item(data_byte(), 1'b1, 1'b0);
                    repeat ($urandom_range(0, 2)) send_item(data_byte(), 1'b0, 1'b0);
                    build_random_read();
                    send_read(1'b1);
                end else begin
                    build_random_read();
                    send_read($urandom_range(0, 9) != 0);
                end
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: slip_telemetry_frame_receiver.f
sv/stfr_pkg.sv
sv/stfr_in_stage.sv
sv/stfr_deframer.sv
sv/stfr_out_stage.sv
sv/slip_telemetry_frame_receiver.sv
verif/tb_top.sv
